@@ sv/arp_pkg.sv @@
package arp_pkg;

  // Relocation type numbers from the ARM ELF ABI
  localparam logic [7:0] R_NONE         = 8'd0;
  localparam logic [7:0] R_ABS32        = 8'd2;
  localparam logic [7:0] R_REL32        = 8'd3;
  localparam logic [7:0] R_ABS16        = 8'd5;
  localparam logic [7:0] R_ABS12        = 8'd6;
  localparam logic [7:0] R_ABS8         = 8'd8;
  localparam logic [7:0] R_GOTOFF       = 8'd24;
  localparam logic [7:0] R_GOTPC        = 8'd25;
  localparam logic [7:0] R_GOT32        = 8'd26;
  localparam logic [7:0] R_CALL         = 8'd28;
  localparam logic [7:0] R_JUMP24       = 8'd29;
  localparam logic [7:0] R_TARGET1      = 8'd38;
  localparam logic [7:0] R_TARGET2      = 8'd41;
  localparam logic [7:0] R_PREL31       = 8'd42;
  localparam logic [7:0] R_MOVW_ABS_NC  = 8'd43;
  localparam logic [7:0] R_MOVT_ABS     = 8'd44;
  localparam logic [7:0] R_MOVW_PREL_NC = 8'd45;
  localparam logic [7:0] R_MOVT_PREL    = 8'd46;
  localparam logic [7:0] R_MOVW_BREL_NC = 8'd84;
  localparam logic [7:0] R_MOVT_BREL    = 8'd85;
  localparam logic [7:0] R_MOVW_BREL    = 8'd86;
  localparam logic [7:0] R_GOT_ABS      = 8'd95;
  localparam logic [7:0] R_GOT_PREL     = 8'd96;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RELAXED  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_VENEER   = 3'd3;
  localparam logic [2:0] ST_NOGOT    = 3'd4;
  localparam logic [2:0] ST_UNKNOWN  = 3'd5;

  // Byte write masks
  localparam logic [3:0] MASK_NONE = 4'h0;
  localparam logic [3:0] MASK_BYTE = 4'h1;
  localparam logic [3:0] MASK_HALF = 4'h3;
  localparam logic [3:0] MASK_WORD = 4'hF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_GOT_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 4'd1;

  // Low 28 bits of the NOP (MOV r0, r0) used by relaxation
  localparam logic [27:0] NOP_LOW = 28'h1A00000;

  // Request after the first register stage: the input-only sums are done
  typedef struct packed {
    logic [7:0]  cmd;
    logic [31:0] sa;       // S + A
    logic [31:0] ap;       // A - P
    logic [31:0] gea;      // GOT entry + A
    logic [31:0] place;
    logic        ge_none;
    logic [31:0] word;
  } arp_item_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic [3:0]  byte_mask;
    logic [2:0]  status;
  } arp_result_t;

  // Place a 16-bit immediate into the MOVW/MOVT imm4:imm12 fields
  function automatic logic [31:0] movw_merge(input logic [31:0] w, input logic [15:0] v);
    movw_merge = {w[31:20], v[15:12], w[15:12], v[11:0]};
  endfunction

endpackage

@@ sv/arp_core.sv @@
module arp_core (
  input  arp_pkg::arp_item_t   item,
  input  logic [31:0]          got_addr,
  input  logic                 relax_en,
  output arp_pkg::arp_result_t result
);

  logic [31:0] sap;
  logic [31:0] gep;
  logic [31:0] goff;
  logic [31:0] gpc;
  logic [31:0] abs12_mag;
  logic [31:0] w;
  logic        fit16;
  logic        fit8;
  logic        fit12;
  logic        fit31;
  logic        fit_branch;
  logic        relax_hit;
  logic [15:0] relax_hi;
  logic [31:0] res;
  logic [3:0]  mask;
  logic [2:0]  st;

  // Second-level sums, one adder deep each
  assign w         = item.word;
  assign sap       = item.sa - item.place;
  assign gep       = item.gea - item.place;
  assign goff      = item.sa - got_addr;
  assign gpc       = got_addr + item.ap;
  assign abs12_mag = item.sa[31] ? (32'd0 - item.sa) : item.sa;

  // Range checks on the sign-extended values
  assign fit16      = (item.sa[31:16] == 16'h0000) || (&item.sa[31:15]);
  assign fit8       = (item.sa[31:8] == 24'h000000) || (&item.sa[31:7]);
  assign fit12      = (abs12_mag[31:12] == 20'h00000);
  assign fit31      = (sap[31] == sap[30]);
  assign fit_branch = (sap[31:25] == 7'h00) || (&sap[31:25]);

  // Detect a MOVT whose upper half is redundant
  assign relax_hi = (item.cmd == arp_pkg::R_MOVT_PREL) ? sap[31:16] : item.sa[31:16];

  always_comb begin
    relax_hit = 1'b0;
    if (relax_en && ((item.cmd == arp_pkg::R_MOVT_ABS) || (item.cmd == arp_pkg::R_MOVT_BREL) ||
                     (item.cmd == arp_pkg::R_MOVT_PREL))) begin
      relax_hit = (relax_hi == 16'h0000) ||
                  ((item.cmd == arp_pkg::R_MOVT_PREL) && (relax_hi == 16'hFFFF));
    end
  end

  // Pick the patch value for each relocation type
  always_comb begin
    res  = w;
    mask = arp_pkg::MASK_WORD;
    st   = arp_pkg::ST_OK;
    unique case (item.cmd)
      arp_pkg::R_NONE: begin
        mask = arp_pkg::MASK_NONE;
      end
      arp_pkg::R_ABS32, arp_pkg::R_TARGET1: begin
        res = item.sa;
      end
      arp_pkg::R_REL32, arp_pkg::R_TARGET2: begin
        res = sap;
      end
      arp_pkg::R_ABS16: begin
        if (!fit16) begin
          st = arp_pkg::ST_OVERFLOW;
        end else begin
          res  = {w[31:16], item.sa[15:0]};
          mask = arp_pkg::MASK_HALF;
        end
      end
      arp_pkg::R_ABS8: begin
        if (!fit8) begin
          st = arp_pkg::ST_OVERFLOW;
        end else begin
          res  = {w[31:8], item.sa[7:0]};
          mask = arp_pkg::MASK_BYTE;
        end
      end
      arp_pkg::R_ABS12: begin
        if (!fit12) begin
          st = arp_pkg::ST_OVERFLOW;
        end else begin
          res = {w[31:24], ~item.sa[31], w[22:12], abs12_mag[11:0]};
        end
      end
      arp_pkg::R_PREL31: begin
        if (!fit31) begin
          st = arp_pkg::ST_OVERFLOW;
        end else begin
          res = {w[31], sap[30:0]};
        end
      end
      arp_pkg::R_CALL, arp_pkg::R_JUMP24: begin
        if (!fit_branch) begin
          st = arp_pkg::ST_VENEER;
        end else begin
          res = {w[31:24], sap[25:2]};
        end
      end
      arp_pkg::R_MOVW_ABS_NC, arp_pkg::R_MOVW_BREL_NC: begin
        res = arp_pkg::movw_merge(w, item.sa[15:0]);
      end
      arp_pkg::R_MOVT_ABS, arp_pkg::R_MOVT_BREL: begin
        res = arp_pkg::movw_merge(w, item.sa[31:16]);
      end
      arp_pkg::R_MOVW_PREL_NC: begin
        res = arp_pkg::movw_merge(w, sap[15:0]);
      end
      arp_pkg::R_MOVT_PREL: begin
        res = arp_pkg::movw_merge(w, sap[31:16]);
      end
      arp_pkg::R_MOVW_BREL: begin
        if (!fit16) begin
          st = arp_pkg::ST_OVERFLOW;
        end else begin
          res = arp_pkg::movw_merge(w, item.sa[15:0]);
        end
      end
      arp_pkg::R_GOT32, arp_pkg::R_GOT_ABS: begin
        if (item.ge_none) begin
          st = arp_pkg::ST_NOGOT;
        end else begin
          res = item.gea;
        end
      end
      arp_pkg::R_GOT_PREL: begin
        if (item.ge_none) begin
          st = arp_pkg::ST_NOGOT;
        end else begin
          res = gep;
        end
      end
      arp_pkg::R_GOTOFF: begin
        if (got_addr == 32'd0) begin
          st = arp_pkg::ST_NOGOT;
        end else begin
          res = goff;
        end
      end
      arp_pkg::R_GOTPC: begin
        if (got_addr == 32'd0) begin
          st = arp_pkg::ST_NOGOT;
        end else begin
          res = gpc;
        end
      end
      default: begin
        st = arp_pkg::ST_UNKNOWN;
      end
    endcase

    // Drop the patch on any error; relaxation overrides everything
    if (st != arp_pkg::ST_OK) begin
      res  = w;
      mask = arp_pkg::MASK_NONE;
    end
    if (relax_hit) begin
      res  = {w[31:28], arp_pkg::NOP_LOW};
      mask = arp_pkg::MASK_WORD;
      st   = arp_pkg::ST_RELAXED;
    end
  end

  assign result.patched_word = res;
  assign result.byte_mask    = mask;
  assign result.status       = st;

endmodule

@@ sv/arm32_relocation_patch.sv @@
// ARM32 ELF relocation patch unit. Each request (start high while busy is
// low) carries one relocation and the word at its place; exactly one result
// follows, shown for a single cycle with out_valid high; it is registered in
// the output register after the input register. The unit takes a request in
// every cycle: S+A, A-P and GOT+A are formed as the request enters the input
// register, and the stage after it finishes the P and GOT-base sums, the
// range checks and the field merge. busy never rises, and the receiver cannot
// stall, so a result must be captured in the cycle it is strobed.
// Configuration writes (cfg_valid, always ready) must come while no request
// is in flight: index 0 is the GOT base, index 1 the MOVT relaxation enable.
module arm32_relocation_patch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [7:0]                   in_cmd,
  input  logic [31:0]                  in_symbol_value,
  input  logic signed [31:0]           in_addend,
  input  logic [31:0]                  in_place,
  input  logic signed [31:0]           in_got_entry,
  input  logic [31:0]                  in_original_word,
  output logic                         out_valid,
  output logic [31:0]                  out_patched_word,
  output logic [3:0]                   out_byte_mask,
  output logic [2:0]                   out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  logic [31:0]          got_addr_r;
  logic                 relax_r;
  logic                 item_vld_r;
  arp_pkg::arp_item_t   item_r;
  arp_pkg::arp_item_t   item_nxt;
  arp_pkg::arp_result_t calc;
  logic                 out_vld_r;
  arp_pkg::arp_result_t res_r;
  logic                 accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      got_addr_r <= 32'd0;
      relax_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == arp_pkg::CFG_GOT_BASE) begin
        got_addr_r <= cfg_data;
      end else if (cfg_index == arp_pkg::CFG_RELAX) begin
        relax_r <= cfg_data[0];
      end
    end
  end

  // Form the first-level sums from the request fields
  always_comb begin
    item_nxt.cmd     = in_cmd;
    item_nxt.sa      = in_symbol_value + unsigned'(in_addend);
    item_nxt.ap      = unsigned'(in_addend) - in_place;
    item_nxt.gea     = unsigned'(in_got_entry) + unsigned'(in_addend);
    item_nxt.place   = in_place;
    item_nxt.ge_none = in_got_entry[31];
    item_nxt.word    = in_original_word;
  end

  // Hold the request in the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= accept;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  arp_core u_core (
    .item     (item_r),
    .got_addr (got_addr_r),
    .relax_en (relax_r),
    .result   (calc)
  );

  // Register the result and strobe it for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= item_vld_r;
    end
    if (item_vld_r) begin
      res_r <= calc;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_patched_word = res_r.patched_word;
  assign out_byte_mask    = res_r.byte_mask;
  assign out_status       = res_r.status;

endmodule
